### design/lae_pkg.sv
// Shared types and constants for the life automaton engine.
package lae_pkg;

  localparam int OPCODE_W   = 2;
  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int COUNT_W    = 4;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [COUNT_W-1:0] KEEP_COUNT  = 4'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd1;

  localparam logic [CFG_DATA_W-1:0] GRID_DIM_RESET = 7'd64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET     = 2'd0,
    OP_TOGGLE  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_READ    = 2'd3
  } lae_op_t;

  // Which neighbouring rows of the window lie inside the active area.
  typedef struct packed {
    logic above_ok;
    logic below_ok;
  } lae_win_ctl_t;

endpackage

### design/lae_row_cell.sv
// One row of the grid: a register stage of the circulating row chain.
module lae_row_cell #(
  parameter int MAX_COLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic [MAX_COLS-1:0] row_in,
  output logic [MAX_COLS-1:0] row_out
);

  logic [MAX_COLS-1:0] row_r;
  logic [MAX_COLS-1:0] row_nxt;

  assign row_nxt = shift_en ? row_in : row_r;
  assign row_out = row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

endmodule

### design/lae_row_rule.sv
// B3/S23 update of one row from a three-row window.
module lae_row_rule #(
  parameter int MAX_COLS = 64
) (
  input  lae_pkg::lae_win_ctl_t ctl,
  input  logic [MAX_COLS-1:0]   above,
  input  logic [MAX_COLS-1:0]   cur,
  input  logic [MAX_COLS-1:0]   below,
  input  logic [MAX_COLS-1:0]   col_mask,
  output logic [MAX_COLS-1:0]   next_row
);
  import lae_pkg::*;

  logic [MAX_COLS-1:0] a_m, c_m, b_m;

  assign a_m = ctl.above_ok ? (above & col_mask) : '0;
  assign c_m = cur & col_mask;
  assign b_m = ctl.below_ok ? (below & col_mask) : '0;

  always_comb begin
    logic [COUNT_W-1:0] n;
    logic               born;
    next_row = cur;
    for (int c = 0; c < MAX_COLS; c++) begin
      n = COUNT_W'(a_m[c]) + COUNT_W'(b_m[c]);
      if (c > 0) begin
        n = n + COUNT_W'(a_m[c-1]) + COUNT_W'(c_m[c-1]) + COUNT_W'(b_m[c-1]);
      end
      if (c < MAX_COLS - 1) begin
        n = n + COUNT_W'(a_m[c+1]) + COUNT_W'(c_m[c+1]) + COUNT_W'(b_m[c+1]);
      end
      born = (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && cur[c]);
      // columns outside the active area keep what they hold
      next_row[c] = col_mask[c] ? born : cur[c];
    end
  end

endmodule

### design/life_automaton_engine.sv
// Top level of the life automaton engine: row chain, head logic and control.
//
// The grid is a ring of MAX_ROWS row registers that rotates one row per cycle
// past a head stage while an item runs. Every item (set, toggle, read or
// advance) takes one full rotation: it is accepted, the ring rotates once,
// and the result is posted once the output register is free. An advance
// applies the B3/S23 rule to the row at the head using the row behind it
// and the row ahead. Set, toggle and read act on their row as it passes
// the head. Cells start dead after reset. Results leave through an output
// register, so the next item is accepted while a result still waits.
// Configuration writes are taken in any cycle and should only be made while
// the block is idle.
module life_automaton_engine #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // cfg
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lae_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lae_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // col [5:0], row [11:6], alive_in [12], zero [15:13]
  input  logic [lae_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode [1:0]
  input  logic [lae_pkg::OPCODE_W-1:0]      in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cell_out [0], zero [7:1]
  output logic [lae_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status [0]
  output logic                              out_tuser
);
  import lae_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CMP_B = ((CNT_W > COL_W) ? CNT_W : COL_W) + 1;
  localparam int CMP_W = (CMP_B > 8) ? CMP_B : 8;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  // configuration
  logic [CFG_DATA_W-1:0] grid_width_r, grid_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_DIM_RESET;
      grid_height_r <= GRID_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_width_r <= cfg_data;
      end else if (cfg_index == REG_GRID_HEIGHT) begin
        grid_height_r <= cfg_data;
      end
    end
  end

  // input fields
  logic [COORD_W-1:0] in_col, in_row;
  logic               in_alive;
  logic               in_oor;

  assign in_col   = in_tdata[COORD_W-1:0];
  assign in_row   = in_tdata[2*COORD_W-1:COORD_W];
  assign in_alive = in_tdata[2*COORD_W];
  assign in_oor   = (CMP_W'(in_col) >= CMP_W'(grid_width_r))  ||
                    (CMP_W'(in_col) >= CMP_W'(MAX_COLS))      ||
                    (CMP_W'(in_row) >= CMP_W'(grid_height_r)) ||
                    (CMP_W'(in_row) >= CMP_W'(MAX_ROWS));

  // control registers
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  lae_op_t             op_r, op_nxt;
  logic [COORD_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic                alive_r, alive_nxt;
  logic                oor_r, oor_nxt;
  logic                cell_r, cell_nxt;
  logic [MAX_COLS-1:0] prev_r, prev_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_cell_r, out_cell_nxt;
  logic                out_status_r, out_status_nxt;

  // row ring
  logic [MAX_COLS-1:0] rows [MAX_ROWS];
  logic [MAX_COLS-1:0] wb_row, mod_row, rule_row, col_mask;
  logic                shift_en, hit, cur_ok;
  lae_win_ctl_t        win_ctl;
  logic [COL_W-1:0]    col_idx;
  logic [CMP_W-1:0]    cnt_w;

  assign shift_en = (state_r == S_RUN);
  assign col_idx  = COL_W'(col_r);
  assign cnt_w    = CMP_W'(cnt_r);
  assign hit      = shift_en && (op_r != OP_ADVANCE) && !oor_r && (cnt_w == CMP_W'(row_r));
  assign cur_ok   = cnt_w < CMP_W'(grid_height_r);

  assign win_ctl.above_ok = (cnt_r != '0);
  assign win_ctl.below_ok = ((cnt_w + 1'b1) < CMP_W'(grid_height_r)) &&
                            ((cnt_w + 1'b1) < CMP_W'(MAX_ROWS));

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = CMP_W'(c) < CMP_W'(grid_width_r);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ROWS; gi++) begin : g_row
      if (gi == MAX_ROWS - 1) begin : g_tail
        lae_row_cell #(.MAX_COLS(MAX_COLS)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .row_in   (wb_row),
          .row_out  (rows[gi])
        );
      end else begin : g_body
        lae_row_cell #(.MAX_COLS(MAX_COLS)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .row_in   (rows[gi+1]),
          .row_out  (rows[gi])
        );
      end
    end
  endgenerate

  lae_row_rule #(.MAX_COLS(MAX_COLS)) u_rule (
    .ctl      (win_ctl),
    .above    (prev_r),
    .cur      (rows[0]),
    .below    (rows[1]),
    .col_mask (col_mask),
    .next_row (rule_row)
  );

  // head stage: single-cell edits and write-back into the tail of the ring
  always_comb begin
    mod_row = rows[0];
    if (hit) begin
      case (op_r)
        OP_SET:    mod_row[col_idx] = alive_r;
        OP_TOGGLE: mod_row[col_idx] = ~rows[0][col_idx];
        default:   mod_row = rows[0];
      endcase
    end
    if (op_r == OP_ADVANCE) begin
      wb_row = cur_ok ? rule_row : rows[0];
    end else begin
      wb_row = mod_row;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    alive_nxt      = alive_r;
    oor_nxt        = oor_r;
    cell_nxt       = cell_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cell_nxt   = out_cell_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = lae_op_t'(in_tuser);
          col_nxt   = in_col;
          row_nxt   = in_row;
          alive_nxt = in_alive;
          oor_nxt   = in_oor && (lae_op_t'(in_tuser) != OP_ADVANCE);
          cell_nxt  = 1'b0;
          prev_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        // the original row at the head becomes the row above for the next step
        prev_nxt = rows[0];
        if (hit) begin
          cell_nxt = mod_row[col_idx];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_w == CMP_W'(MAX_ROWS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_cell_nxt   = cell_r;
          out_status_nxt = oor_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    alive_r      <= alive_nxt;
    oor_r        <= oor_nxt;
    cell_r       <= cell_nxt;
    prev_r       <= prev_nxt;
    out_cell_r   <= out_cell_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_cell_r};
  assign out_tuser  = out_status_r;

  // checks
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_RUN)
    else $error("accepted transaction did not start a rotation");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result posted outside the done state");

  a_flagged_cell_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[0] == 1'b0)
    else $error("flagged result carries a live cell");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_RUN |-> cnt_r == '0)
    else $error("row counter not cleared outside a rotation");

endmodule
